// File: design/owm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the omni wheel motion mixer
// Command codes, state encoding and controller to datapath signal groups.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam logic [2:0] MODE_STOP  = 3'd0;
	localparam logic [2:0] MODE_TURN  = 3'd1;
	localparam logic [2:0] MODE_DASH  = 3'd2;
	localparam logic [2:0] MODE_SKICK = 3'd3;
	localparam logic [2:0] MODE_KICK  = 3'd4;
	localparam logic [2:0] MODE_CATCH = 3'd5;

	localparam logic [2:0] REG_COS_FRONT = 3'd0;
	localparam logic [2:0] REG_SIN_FRONT = 3'd1;
	localparam logic [2:0] REG_COS_BACK  = 3'd2;
	localparam logic [2:0] REG_SIN_BACK  = 3'd3;
	localparam logic [2:0] REG_INV_RAD   = 3'd4;
	localparam logic [2:0] REG_RATIO     = 3'd5;

	localparam logic signed [17:0] DASH_GAIN_Q24 = 18'sd100663;
	localparam logic signed [7:0]  CATCH_LEVEL   = 8'sd100;
	// ceil(2^34 / 5): floor(2a / 5) is (a * DECAY_RECIP) >> 33 for any 32-bit a
	localparam logic [31:0]        DECAY_RECIP   = 32'hCCCCCCCD;

	// datapath micro-operations, one per cycle
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,     // latch command, apply mode effects
		OP_SIN_PREP, // quarter folding for sin or cos
		OP_X2,
		OP_P1,
		OP_P2,
		OP_P3,
		OP_DASH_MUL, // power * sine
		OP_DASH_GAIN,// * gain, round
		OP_DASH_ACC, // accumulate and saturate
		OP_MIX_A,    // first product of a wheel
		OP_MIX_B,    // second product, sum, round
		OP_LIN,      // * inv radius
		OP_SPIN_A,
		OP_SPIN_B,
		OP_WHEEL,    // add spin, *100, round, saturate
		OP_FINISH    // decay and clear short-kick dribbler
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       sel_cos; // second dash axis
		logic [1:0] wheel;
	} dp_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DASH  = 5'b00010,
		ST_MIX   = 5'b00100,
		ST_OUT   = 5'b01000,
		ST_WAIT  = 5'b10000
	} state_t;

	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
			input int n);
		logic signed [63:0] half;
		logic signed [63:0] a;
		half = 64'sd1 <<< (n - 1);
		a = (v < 0) ? -v : v;
		a = (a + half) >>> n;
		return (v < 0) ? -a : a;
	endfunction

endpackage
`default_nettype wire

// File: design/omni_wheel_motion_mixer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// omni_wheel_motion_mixer_top: four-wheel omni drive motion mixer
// Takes one motion command, updates body velocity and dribbler, emits wheels.
// ----------------------------------------------------------------------------
// One command at a time, worked through as a sequence of multiply steps, one per
// cycle. A dash first runs two sine evaluations, one per axis, ahead of the four
// wheel mixes. The input stays closed until the result transfer, so a new command
// is accepted only after the previous result has been taken.
// Modes 6 and 7 are accepted and dropped with no result.
module omni_wheel_motion_mixer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // mode, power, direction, turn_rate
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // speeds fr, br, bl, fl, dribbler_drive
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_data
);
	owm_pkg::dp_cmd_t cmd;
	logic busy, fire, valid_cmd;

	assign s_axis_tready = !busy;
	assign fire = s_axis_tvalid && s_axis_tready;
	assign valid_cmd = fire && (s_axis_tdata[2:0] <= owm_pkg::MODE_CATCH);

	owm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(valid_cmd), .mode(s_axis_tdata[2:0]),
		.out_taken(m_axis_tready), .busy(busy), .out_valid(m_axis_tvalid), .cmd(cmd)
	);

	owm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .mode(s_axis_tdata[2:0]),
		.power(s_axis_tdata[18:3]), .direction(s_axis_tdata[34:19]),
		.turn_rate(s_axis_tdata[50:35]), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .result(m_axis_tdata)
	);
endmodule
`default_nettype wire

// File: design/owm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owm_dp: motion mixer datapath
// State registers, multiply steps sequenced by the controller, result registers.
// ----------------------------------------------------------------------------
module owm_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire owm_pkg::dp_cmd_t    cmd,
	input  wire logic [2:0]          mode,
	input  wire logic signed [15:0]  power,
	input  wire logic [15:0]         direction,
	input  wire logic signed [15:0]  turn_rate,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_idx,
	input  wire logic [15:0]         cfg_data,
	output logic [71:0]              result
);
	logic signed [15:0] cos_front_q, sin_front_q, cos_back_q, sin_back_q;
	logic [15:0] inv_rad_q, ratio_q;
	logic signed [31:0] u_q, v_q;
	logic signed [15:0] w_q;
	logic signed [7:0] drib_q;
	logic [2:0] mode_q;
	logic signed [15:0] power_q;
	logic [15:0] dir_q;
	logic [14:0] x_q;
	logic neg_q;
	logic signed [31:0] x2_q;
	logic signed [63:0] acc_q, spin_q;
	logic signed [15:0] sp_q [4];
	logic signed [63:0] m, mw;
	logic [15:0] a;
	logic signed [63:0] t;
	logic signed [31:0] sel_a, sel_b;
	logic signed [63:0] nu, nv;
	logic [31:0] mag_u, mag_v;
	logic [63:0] prod_u, prod_v;
	logic signed [31:0] dec_u, dec_v;

	always_comb begin
		a = dir_q + (cmd.sel_cos ? 16'h4000 : 16'h0000);
		unique case (cmd.wheel)
			2'd0: begin sel_a = -32'(sin_front_q); sel_b = -32'(cos_front_q); end
			2'd1: begin sel_a =  32'(sin_back_q);  sel_b = -32'(cos_back_q);  end
			2'd2: begin sel_a =  32'(sin_back_q);  sel_b =  32'(cos_back_q);  end
			default: begin sel_a = -32'(sin_front_q); sel_b = 32'(cos_front_q); end
		endcase
		nu = 64'(u_q) + acc_q;
		nv = 64'(v_q) + acc_q;
		t = owm_pkg::rnd_shift(-64'(power), 8);
		m = owm_pkg::rnd_shift(64'($signed(acc_q[31:0])) * 64'(x_q), 14);
		mw = owm_pkg::rnd_shift((acc_q + spin_q) * 100, 24);
		// decay to 2/5 of the value, toward zero, through a reciprocal multiply
		mag_u = u_q[31] ? -u_q : u_q;
		mag_v = v_q[31] ? -v_q : v_q;
		prod_u = 64'(mag_u) * 64'(owm_pkg::DECAY_RECIP);
		prod_v = 64'(mag_v) * 64'(owm_pkg::DECAY_RECIP);
		dec_u = u_q[31] ? -$signed({1'b0, prod_u[63:33]}) : $signed({1'b0, prod_u[63:33]});
		dec_v = v_q[31] ? -$signed({1'b0, prod_v[63:33]}) : $signed({1'b0, prod_v[63:33]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_front_q <= '0; sin_front_q <= 16'sd32767;
			cos_back_q <= '0; sin_back_q <= 16'sd32767;
			inv_rad_q <= 16'd256; ratio_q <= 16'd256;
			u_q <= '0; v_q <= '0; w_q <= '0; drib_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					owm_pkg::REG_COS_FRONT: cos_front_q <= cfg_data;
					owm_pkg::REG_SIN_FRONT: sin_front_q <= cfg_data;
					owm_pkg::REG_COS_BACK:  cos_back_q <= cfg_data;
					owm_pkg::REG_SIN_BACK:  sin_back_q <= cfg_data;
					owm_pkg::REG_INV_RAD:   inv_rad_q <= cfg_data;
					owm_pkg::REG_RATIO:     ratio_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				owm_pkg::OP_LOAD: begin
					case (mode)
						owm_pkg::MODE_STOP: begin
							u_q <= '0; v_q <= '0; w_q <= '0; drib_q <= '0;
						end
						owm_pkg::MODE_TURN: w_q <= turn_rate;
						owm_pkg::MODE_SKICK: begin
							drib_q <= (t > 127) ? 8'sd127 : (t < -128) ? -8'sd128 : t[7:0];
							w_q <= '0;
						end
						owm_pkg::MODE_CATCH: begin
							drib_q <= owm_pkg::CATCH_LEVEL; w_q <= '0;
						end
						default: begin
							if (mode == owm_pkg::MODE_KICK) drib_q <= '0;
							w_q <= '0;
						end
					endcase
				end
				owm_pkg::OP_DASH_ACC: begin
					if (!cmd.sel_cos)
						u_q <= (nu > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
							(nu < -64'sh80000000) ? 32'sh80000000 : nu[31:0];
					else
						v_q <= (nv > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
							(nv < -64'sh80000000) ? 32'sh80000000 : nv[31:0];
				end
				owm_pkg::OP_FINISH: begin
					if (mode_q == owm_pkg::MODE_SKICK) drib_q <= '0;
					u_q <= dec_u;
					v_q <= dec_v;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			owm_pkg::OP_LOAD: begin
				mode_q <= mode; power_q <= power; dir_q <= direction;
			end
			owm_pkg::OP_SIN_PREP: begin
				x_q <= a[14] ? 15'(16384 - 32'(a[13:0])) : {1'b0, a[13:0]};
				neg_q <= a[15];
			end
			owm_pkg::OP_X2: begin
				x2_q <= 32'(owm_pkg::rnd_shift(64'(x_q) * 64'(x_q), 14));
				acc_q <= 64'sd2320;
			end
			owm_pkg::OP_P1:
				acc_q <= owm_pkg::rnd_shift(64'($signed(acc_q[31:0])) * 64'(x2_q), 14) - 21024;
			owm_pkg::OP_P2:
				acc_q <= owm_pkg::rnd_shift(64'($signed(acc_q[31:0])) * 64'(x2_q), 14) + 51472;
			owm_pkg::OP_P3: acc_q <= neg_q ? -m : m;
			owm_pkg::OP_DASH_MUL: acc_q <= 64'(power_q) * 64'($signed(acc_q[17:0]));
			owm_pkg::OP_DASH_GAIN:
				acc_q <= owm_pkg::rnd_shift(64'($signed(acc_q[31:0])) *
					64'(owm_pkg::DASH_GAIN_Q24), 31);
			owm_pkg::OP_MIX_A: acc_q <= 64'(sel_a) * 64'(u_q);
			owm_pkg::OP_MIX_B: acc_q <= owm_pkg::rnd_shift(acc_q + 64'(sel_b) * 64'(v_q), 15);
			owm_pkg::OP_LIN: acc_q <= 64'($signed(acc_q[33:0])) * 64'(inv_rad_q);
			owm_pkg::OP_SPIN_A: spin_q <= 64'(w_q) * 64'(ratio_q);
			owm_pkg::OP_SPIN_B: spin_q <= 64'($signed(spin_q[31:0])) * 64'(inv_rad_q);
			owm_pkg::OP_WHEEL:
				sp_q[cmd.wheel] <= (mw > 32767) ? 16'sh7FFF : (mw < -32768) ? 16'sh8000 :
					mw[15:0];
			default: ;
		endcase
	end

	assign result = {drib_q, sp_q[3], sp_q[2], sp_q[1], sp_q[0]};
endmodule
`default_nettype wire

// File: design/owm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owm_ctrl: motion mixer controller
// Sequences the datapath steps of one command and holds the output handshake.
// ----------------------------------------------------------------------------
module owm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire logic [2:0]       mode,
	input  wire logic             out_taken,
	output logic                  busy,
	output logic                  out_valid,
	output owm_pkg::dp_cmd_t      cmd
);
	owm_pkg::state_t st_q;
	logic [3:0] step_q;
	logic [1:0] wheel_q;
	logic axis_q;

	assign busy = (st_q != owm_pkg::ST_IDLE);
	assign out_valid = (st_q == owm_pkg::ST_WAIT);

	always_comb begin
		cmd = '{op: owm_pkg::OP_NONE, sel_cos: axis_q, wheel: wheel_q};
		unique case (st_q)
			owm_pkg::ST_IDLE: if (in_fire) cmd.op = owm_pkg::OP_LOAD;
			owm_pkg::ST_DASH: begin
				case (step_q)
					4'd0: cmd.op = owm_pkg::OP_SIN_PREP;
					4'd1: cmd.op = owm_pkg::OP_X2;
					4'd2: cmd.op = owm_pkg::OP_P1;
					4'd3: cmd.op = owm_pkg::OP_P2;
					4'd4: cmd.op = owm_pkg::OP_P3;
					4'd5: cmd.op = owm_pkg::OP_DASH_MUL;
					4'd6: cmd.op = owm_pkg::OP_DASH_GAIN;
					default: cmd.op = owm_pkg::OP_DASH_ACC;
				endcase
			end
			owm_pkg::ST_MIX: begin
				case (step_q)
					4'd0: cmd.op = owm_pkg::OP_SPIN_A;
					4'd1: cmd.op = owm_pkg::OP_SPIN_B;
					4'd2: cmd.op = owm_pkg::OP_MIX_A;
					4'd3: cmd.op = owm_pkg::OP_MIX_B;
					4'd4: cmd.op = owm_pkg::OP_LIN;
					default: cmd.op = owm_pkg::OP_WHEEL;
				endcase
			end
			owm_pkg::ST_OUT: cmd.op = owm_pkg::OP_NONE;
			owm_pkg::ST_WAIT: if (out_taken) cmd.op = owm_pkg::OP_FINISH;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= owm_pkg::ST_IDLE; step_q <= '0; wheel_q <= '0; axis_q <= 1'b0;
		end else begin
			unique case (st_q)
				owm_pkg::ST_IDLE: if (in_fire) begin
					step_q <= '0; wheel_q <= '0; axis_q <= 1'b0;
					st_q <= (mode == owm_pkg::MODE_DASH) ? owm_pkg::ST_DASH : owm_pkg::ST_MIX;
				end
				owm_pkg::ST_DASH: begin
					if (step_q == 4'd7) begin
						step_q <= '0;
						axis_q <= 1'b1;
						if (axis_q) st_q <= owm_pkg::ST_MIX;
					end else step_q <= step_q + 4'd1;
				end
				owm_pkg::ST_MIX: begin
					if (step_q == 4'd5) begin
						wheel_q <= wheel_q + 2'd1;
						step_q <= 4'd2;
						if (wheel_q == 2'd3) st_q <= owm_pkg::ST_OUT;
					end else step_q <= step_q + 4'd1;
				end
				owm_pkg::ST_OUT: st_q <= owm_pkg::ST_WAIT;
				owm_pkg::ST_WAIT: if (out_taken) st_q <= owm_pkg::ST_IDLE;
				default: st_q <= owm_pkg::ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/owm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owm_checker: port-level checks of the motion mixer
// Handshake and sequencing rules seen at the top level ports.
// ----------------------------------------------------------------------------
module owm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [71:0] m_axis_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input open with result held");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind omni_wheel_motion_mixer_top owm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
